>>> rtl/bais_pkg.sv
// Shared types and constants of the brace arity interpolation splitter.
`timescale 1ns / 1ps

package bais_pkg;

    localparam int unsigned MAX_RUN_DEFAULT = 255;

    localparam logic [7:0] LBRACE = 8'h7B;
    localparam logic [7:0] RBRACE = 8'h7D;

    // Results one item can cause at most, and the result queue behind them
    localparam int unsigned MAX_PUSH   = 3;
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_VAL_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BRACE_ARITY        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERPOLATE_ENABLE = 2'd1;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_byte;
    } item_t;

    typedef struct packed {
        logic       part_kind;
        logic [7:0] out_byte;
        logic [7:0] repeat_res;
        logic       part_close;
        logic       unterminated;
        logic       string_done;
        logic       last_of_step;
    } res_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } cfg_t;

    function automatic res_t mk_res(
        input logic       pk,
        input logic [7:0] b,
        input logic [7:0] rep,
        input logic       cl,
        input logic       un,
        input logic       dn
    );
        res_t r;
        r.part_kind    = pk;
        r.out_byte     = (rep == 8'd0) ? 8'd0 : b;
        r.repeat_res   = rep;
        r.part_close   = cl;
        r.unterminated = un;
        r.string_done  = dn;
        r.last_of_step = 1'b0;
        return r;
    endfunction

endpackage

>>> rtl/bais_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
`timescale 1ns / 1ps

interface bais_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/brace_arity_interpolation_splitter.sv
// Top level of the brace arity interpolation splitter.
`timescale 1ns / 1ps
//
// Splits a string, one byte per item on "items", into static and expression
// parts; the end of string comes as an item with kind = 1. Results leave on
// "results", one per handshake, last_of_step marking the last one of an item.
// Registers on "cfg": index 0 brace_arity, 1 interpolate_enable; a write to
// either aborts the string in progress. Write only while the block is idle.
//
// Throughput: one item per cycle while the queue has room. An item is
// registered at acceptance and decoded from that register, which pushes its
// 0 to 3 results into an 8-entry result queue in front of an output register;
// the first result passes through the queue and the output register before
// it is offered. The queue drains one result per cycle while the receiver
// takes them, so items stall only while fewer than three entries are free.
// A stalled receiver holds the head result; the queue fills and items stop.
// Reset: brace_arity = 1, interpolate_enable = 1, static mode, queue empty.
// "cfg" is always ready.

module brace_arity_interpolation_splitter
    import bais_pkg::*;
#(
    parameter int unsigned MAX_RUN = MAX_RUN_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bais_stream_if.sink          items,
    bais_stream_if.source        results,
    bais_stream_if.sink          cfg
);

    localparam int unsigned RW = $clog2(MAX_RUN + 1);
    localparam int unsigned SW = (RW > 8) ? RW : 8;

    // Configuration
    logic [3:0] arity_reg;
    logic       enable_reg;

    // Input stage
    logic       stg_valid_reg;
    logic       stg_kind_reg;
    logic [7:0] stg_char_reg;

    // String state
    logic          in_expr_reg, in_expr_next;
    logic [RW-1:0] run_reg, run_next;
    logic          spo_reg, spo_next;

    // Result queue and the output register it feeds
    res_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    res_t               head_reg;
    logic               head_valid_reg;

    res_t       res_v [MAX_PUSH];
    logic [1:0] n_push;
    logic       stg_fire;
    logic       pop;
    logic       load;
    logic       cfg_wr;
    logic [3:0] a_eff;
    logic       run_zero;
    logic       run_lt_a;
    logic       run_gt_a;
    logic [7:0] run8;
    logic [7:0] surplus8;
    logic [RW-1:0] run_bump;
    logic [SW-1:0] surplus_w;

    function automatic logic [7:0] sat8(input logic [SW-1:0] v);
        return (v > SW'(255)) ? 8'd255 : v[7:0];
    endfunction

    assign cfg_wr      = cfg.valid && cfg.ready;
    assign cfg.ready   = 1'b1;
    assign stg_fire    = stg_valid_reg &&
                         (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_PUSH));
    assign items.ready = !stg_valid_reg || stg_fire;
    assign pop         = results.valid && results.ready;
    // Refill the output register from a non-empty queue whenever it is empty or being taken
    assign load        = (count_reg != '0) && (!head_valid_reg || pop);
    assign results.valid = head_valid_reg;
    assign results.data  = head_reg;

    assign a_eff     = (arity_reg == 4'd0) ? 4'd1 : arity_reg;
    assign run_zero  = (run_reg == '0);
    assign run_lt_a  = (SW'(run_reg) < SW'(a_eff));
    assign run_gt_a  = (SW'(run_reg) > SW'(a_eff));
    assign run8      = sat8(SW'(run_reg));
    assign surplus_w = SW'(run_reg) - SW'(a_eff);
    assign surplus8  = sat8(surplus_w);
    assign run_bump  = (run_reg == RW'(MAX_RUN)) ? run_reg : run_reg + RW'(1);

    always_comb
    begin
        logic c_lb;
        logic c_rb;
        c_lb = (stg_char_reg == LBRACE);
        c_rb = (stg_char_reg == RBRACE);
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            res_v[i] = '0;
        end
        n_push       = 2'd0;
        in_expr_next = in_expr_reg;
        run_next     = run_reg;
        spo_next     = spo_reg;

        if (!enable_reg)
        begin
            if (stg_kind_reg)
            begin
                res_v[n_push] = mk_res(1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1);
                n_push = n_push + 2'd1;
                in_expr_next = 1'b0;
                run_next = '0;
                spo_next = 1'b0;
            end
            else
            begin
                res_v[n_push] = mk_res(1'b0, stg_char_reg, 8'd1, 1'b0, 1'b0, 1'b0);
                n_push = n_push + 2'd1;
                spo_next = 1'b1;
            end
        end
        else if (stg_kind_reg)
        begin
            if (!in_expr_reg)
            begin
                if (run_zero)
                begin
                    res_v[n_push] = mk_res(1'b0, 8'd0, 8'd0, spo_reg, 1'b0, 1'b1);
                    n_push = n_push + 2'd1;
                end
                else if (run_lt_a)
                begin
                    res_v[n_push] = mk_res(1'b0, LBRACE, run8, 1'b1, 1'b0, 1'b1);
                    n_push = n_push + 2'd1;
                end
                else
                begin
                    if (spo_reg)
                    begin
                        res_v[n_push] = mk_res(1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
                        n_push = n_push + 2'd1;
                    end
                    if (run_gt_a)
                    begin
                        res_v[n_push] = mk_res(1'b0, LBRACE, surplus8, 1'b1, 1'b0, 1'b0);
                        n_push = n_push + 2'd1;
                    end
                    res_v[n_push] = mk_res(1'b1, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1);
                    n_push = n_push + 2'd1;
                end
            end
            else
            begin
                if (!run_lt_a)
                begin
                    res_v[n_push] = mk_res(1'b1, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1);
                end
                else
                begin
                    res_v[n_push] = mk_res(1'b1, RBRACE, run8, 1'b1, 1'b1, 1'b1);
                end
                n_push = n_push + 2'd1;
            end
            in_expr_next = 1'b0;
            run_next = '0;
            spo_next = 1'b0;
        end
        else if (!in_expr_reg)
        begin
            if (run_zero)
            begin
                if (c_lb)
                begin
                    run_next = RW'(1);
                end
                else
                begin
                    res_v[n_push] = mk_res(1'b0, stg_char_reg, 8'd1, 1'b0, 1'b0, 1'b0);
                    n_push = n_push + 2'd1;
                    spo_next = 1'b1;
                end
            end
            else if (c_lb)
            begin
                run_next = run_bump;
            end
            else
            begin
                run_next = '0;
                if (run_lt_a)
                begin
                    // Short run is plain text, then the byte that ended it
                    res_v[n_push] = mk_res(1'b0, LBRACE, run8, 1'b0, 1'b0, 1'b0);
                    n_push = n_push + 2'd1;
                    res_v[n_push] = mk_res(1'b0, stg_char_reg, 8'd1, 1'b0, 1'b0, 1'b0);
                    n_push = n_push + 2'd1;
                    spo_next = 1'b1;
                end
                else
                begin
                    if (spo_reg)
                    begin
                        res_v[n_push] = mk_res(1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
                        n_push = n_push + 2'd1;
                    end
                    spo_next = 1'b0;
                    if (run_gt_a)
                    begin
                        res_v[n_push] = mk_res(1'b0, LBRACE, surplus8, 1'b1, 1'b0, 1'b0);
                        n_push = n_push + 2'd1;
                    end
                    in_expr_next = 1'b1;
                    if (c_rb)
                    begin
                        run_next = RW'(1);
                    end
                    else
                    begin
                        res_v[n_push] = mk_res(1'b1, stg_char_reg, 8'd1, 1'b0, 1'b0, 1'b0);
                        n_push = n_push + 2'd1;
                    end
                end
            end
        end
        else
        begin
            if (run_zero)
            begin
                if (c_rb)
                begin
                    run_next = RW'(1);
                end
                else
                begin
                    res_v[n_push] = mk_res(1'b1, stg_char_reg, 8'd1, 1'b0, 1'b0, 1'b0);
                    n_push = n_push + 2'd1;
                end
            end
            else if (c_rb)
            begin
                run_next = run_bump;
            end
            else
            begin
                run_next = '0;
                if (run_lt_a)
                begin
                    res_v[n_push] = mk_res(1'b1, RBRACE, run8, 1'b0, 1'b0, 1'b0);
                    n_push = n_push + 2'd1;
                    res_v[n_push] = mk_res(1'b1, stg_char_reg, 8'd1, 1'b0, 1'b0, 1'b0);
                    n_push = n_push + 2'd1;
                end
                else
                begin
                    // Close the expression; surplus closing braces are dropped
                    res_v[n_push] = mk_res(1'b1, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
                    n_push = n_push + 2'd1;
                    in_expr_next = 1'b0;
                    if (c_lb)
                    begin
                        run_next = RW'(1);
                    end
                    else
                    begin
                        res_v[n_push] = mk_res(1'b0, stg_char_reg, 8'd1, 1'b0, 1'b0, 1'b0);
                        n_push = n_push + 2'd1;
                        spo_next = 1'b1;
                    end
                end
            end
        end

        if (n_push != 2'd0)
        begin
            res_v[n_push - 2'd1].last_of_step = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arity_reg      <= 4'd1;
            enable_reg     <= 1'b1;
            stg_valid_reg  <= 1'b0;
            in_expr_reg    <= 1'b0;
            run_reg        <= '0;
            spo_reg        <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (items.ready)
            begin
                stg_valid_reg <= items.valid;
            end

            if (cfg_wr && (cfg.data.index == REG_BRACE_ARITY ||
                           cfg.data.index == REG_INTERPOLATE_ENABLE))
            begin
                if (cfg.data.index == REG_BRACE_ARITY)
                begin
                    arity_reg <= cfg.data.value;
                end
                else
                begin
                    enable_reg <= cfg.data.value[0];
                end
                // Abort the string in progress
                in_expr_reg <= 1'b0;
                run_reg     <= '0;
                spo_reg     <= 1'b0;
            end
            else if (stg_fire)
            begin
                in_expr_reg <= in_expr_next;
                run_reg     <= run_next;
                spo_reg     <= spo_next;
            end

            if (stg_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(n_push);
            end
            if (load)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + (stg_fire ? (FIFO_AW+1)'(n_push) : '0)
                                   - (load ? (FIFO_AW+1)'(1) : '0);

            if (load)
            begin
                head_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                head_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: input stage, result queue entries and output register
    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            stg_kind_reg <= items.data.kind;
            stg_char_reg <= items.data.char_byte;
        end
        if (stg_fire)
        begin
            for (int i = 0; i < MAX_PUSH; i++)
            begin
                if (2'(i) < n_push)
                begin
                    mem[wr_ptr_reg + FIFO_AW'(i)] <= res_v[i];
                end
            end
        end
        if (load)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

endmodule
